FILE: hdl/gesc_pkg.sv
// Shared types, constants and helpers for the graph edge store with connectivity check.
`default_nettype none

package gesc_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int OP_W         = 2;
   localparam int VERT_W       = 6;
   localparam int NV_W         = 7;

   localparam logic [NV_W-1:0] NV_RESET = 7'd64;

   typedef logic [MAX_VERTICES-1:0] row_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [CNT_W-1:0]        cnt_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CHECK  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_A,
      ST_WR_A,
      ST_RD_B,
      ST_WR_B,
      ST_CLEAR,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic    rd_en;
      idx_type rd_addr;
      logic    wr_en;
      idx_type wr_addr;
      row_type wr_data;
      logic    clear;
   } mem_req_type;

   typedef struct packed {
      logic valid;
      logic connected;
      logic error;
   } result_type;

   function automatic cnt_type used_vertices(input logic [NV_W-1:0] nv);
      if (int'(nv) > MAX_VERTICES) begin
         return CNT_W'(MAX_VERTICES);
      end
      return CNT_W'(nv);
   endfunction

   function automatic row_type in_use_mask(input cnt_type nv_used);
      row_type mask;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         mask[i] = (i < int'(nv_used));
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/gesc_row_mem.sv
// Adjacency row memory with per-row valid bits that read an unwritten row as zero.
`default_nettype none

module gesc_row_mem (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gesc_pkg::mem_req_type mem_req,
   output gesc_pkg::row_type          rd_data
);

   gesc_pkg::row_type mem [gesc_pkg::MAX_VERTICES];
   logic [gesc_pkg::MAX_VERTICES-1:0] valid_ff;
   logic [gesc_pkg::MAX_VERTICES-1:0] valid_in;
   gesc_pkg::row_type                 rd_raw_ff;
   logic                              rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (mem_req.clear) begin
         valid_in = '0;
      end else if (mem_req.wr_en) begin
         valid_in[mem_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_raw_ff   <= mem[mem_req.rd_addr];
         rd_valid_ff <= valid_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

`default_nettype wire

FILE: hdl/gesc_seq.sv
// Sequencer for edge updates, matrix clear and the row-by-row reachability walk.
`default_nettype none

module gesc_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [gesc_pkg::NV_W-1:0]     num_vertices,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [gesc_pkg::OP_W-1:0]     req_op,
   input  wire logic [gesc_pkg::VERT_W-1:0]   req_vertex_a,
   input  wire logic [gesc_pkg::VERT_W-1:0]   req_vertex_b,
   input  wire logic                          res_free,
   output gesc_pkg::result_type               res,
   output gesc_pkg::mem_req_type              mem_req,
   input  wire gesc_pkg::row_type             rd_data
);

   gesc_pkg::state_type state_ff, state_in;
   gesc_pkg::op_type    op_ff, op_in;
   gesc_pkg::idx_type   idx_a_ff, idx_a_in;
   gesc_pkg::idx_type   idx_b_ff, idx_b_in;
   logic                err_ff, err_in;
   gesc_pkg::cnt_type   nv_used_ff, nv_used_in;
   gesc_pkg::row_type   mask_ff, mask_in;
   gesc_pkg::row_type   visited_ff, visited_in;
   gesc_pkg::row_type   expanded_ff, expanded_in;
   gesc_pkg::cnt_type   scan_ff, scan_in;
   logic                pend_ff, pend_in;
   gesc_pkg::idx_type   pend_idx_ff, pend_idx_in;
   logic                progress_ff, progress_in;

   logic                accept;
   gesc_pkg::op_type    req_op_enum;
   gesc_pkg::cnt_type   nv_cur;
   gesc_pkg::row_type   mask_cur;
   logic                req_bad;
   logic                issue;
   logic                pass_end;
   logic                expand;
   logic                full;
   gesc_pkg::row_type   bit_a;
   gesc_pkg::row_type   bit_b;
   logic                is_add;

   assign accept      = req_valid && req_ready;
   assign req_op_enum = gesc_pkg::op_type'(req_op);
   assign nv_cur      = gesc_pkg::used_vertices(num_vertices);
   assign mask_cur    = gesc_pkg::in_use_mask(nv_cur);
   assign req_bad     = (int'(req_vertex_a) >= int'(nv_cur)) ||
                        (int'(req_vertex_b) >= int'(nv_cur));
   assign issue       = (scan_ff < nv_used_ff);
   assign pass_end    = !issue && !pend_ff;
   assign expand      = pend_ff && visited_ff[pend_idx_ff] && !expanded_ff[pend_idx_ff];
   assign full        = ((visited_ff & mask_ff) == mask_ff);
   assign bit_a       = gesc_pkg::row_type'(1) << idx_a_ff;
   assign bit_b       = gesc_pkg::row_type'(1) << idx_b_ff;
   assign is_add      = (op_ff == gesc_pkg::OP_ADD);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gesc_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_op_enum)
                  gesc_pkg::OP_ADD,
                  gesc_pkg::OP_REMOVE: state_in = req_bad ? gesc_pkg::ST_DONE : gesc_pkg::ST_RD_A;
                  gesc_pkg::OP_CHECK:  state_in = gesc_pkg::ST_WALK;
                  gesc_pkg::OP_CLEAR:  state_in = gesc_pkg::ST_CLEAR;
                  default:             state_in = gesc_pkg::ST_IDLE;
               endcase
            end
         end
         gesc_pkg::ST_RD_A:  state_in = gesc_pkg::ST_WR_A;
         gesc_pkg::ST_WR_A:  state_in = gesc_pkg::ST_RD_B;
         gesc_pkg::ST_RD_B:  state_in = gesc_pkg::ST_WR_B;
         gesc_pkg::ST_WR_B:  state_in = gesc_pkg::ST_DONE;
         gesc_pkg::ST_CLEAR: state_in = gesc_pkg::ST_DONE;
         gesc_pkg::ST_WALK: begin
            if (pass_end && !progress_ff) begin
               state_in = gesc_pkg::ST_DONE;
            end
         end
         gesc_pkg::ST_DONE: begin
            if (res_free) begin
               state_in = gesc_pkg::ST_IDLE;
            end
         end
         default: state_in = gesc_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready     = 1'b0;
      mem_req       = '0;
      res           = '0;
      unique case (state_ff)
         gesc_pkg::ST_IDLE: req_ready = 1'b1;
         gesc_pkg::ST_RD_A: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_a_ff;
         end
         gesc_pkg::ST_WR_A: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_a_ff;
            mem_req.wr_data = is_add ? (rd_data | bit_b) : (rd_data & ~bit_b);
         end
         gesc_pkg::ST_RD_B: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_b_ff;
         end
         gesc_pkg::ST_WR_B: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_b_ff;
            mem_req.wr_data = is_add ? (rd_data | bit_a) : (rd_data & ~bit_a);
         end
         gesc_pkg::ST_CLEAR: mem_req.clear = 1'b1;
         gesc_pkg::ST_WALK: begin
            mem_req.rd_en   = issue;
            mem_req.rd_addr = scan_ff[gesc_pkg::IDX_W-1:0];
         end
         gesc_pkg::ST_DONE: begin
            res.valid     = res_free;
            res.connected = (op_ff == gesc_pkg::OP_CHECK) && full;
            res.error     = err_ff;
         end
         default: req_ready = 1'b0;
      endcase
   end

   // Request capture and walk datapath.
   always_comb begin
      op_in       = op_ff;
      idx_a_in    = idx_a_ff;
      idx_b_in    = idx_b_ff;
      err_in      = err_ff;
      nv_used_in  = nv_used_ff;
      mask_in     = mask_ff;
      visited_in  = visited_ff;
      expanded_in = expanded_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      progress_in = progress_ff;
      if (accept) begin
         op_in       = req_op_enum;
         idx_a_in    = gesc_pkg::IDX_W'(req_vertex_a);
         idx_b_in    = gesc_pkg::IDX_W'(req_vertex_b);
         err_in      = ((req_op_enum == gesc_pkg::OP_ADD) ||
                        (req_op_enum == gesc_pkg::OP_REMOVE)) && req_bad;
         nv_used_in  = nv_cur;
         mask_in     = mask_cur;
         visited_in  = mask_cur & gesc_pkg::row_type'(1);
         expanded_in = '0;
         scan_in     = '0;
         pend_in     = 1'b0;
         progress_in = 1'b0;
      end else if (state_ff == gesc_pkg::ST_WALK) begin
         pend_in     = issue;
         pend_idx_in = scan_ff[gesc_pkg::IDX_W-1:0];
         if (issue) begin
            scan_in = scan_ff + gesc_pkg::cnt_type'(1);
         end
         if (expand) begin
            visited_in               = visited_ff | (rd_data & mask_ff);
            expanded_in[pend_idx_ff] = 1'b1;
            progress_in              = 1'b1;
         end
         if (pass_end && progress_ff) begin
            scan_in     = '0;
            progress_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gesc_pkg::ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_a_ff    <= idx_a_in;
      idx_b_ff    <= idx_b_in;
      err_ff      <= err_in;
      nv_used_ff  <= nv_used_in;
      mask_ff     <= mask_in;
      visited_ff  <= visited_in;
      expanded_ff <= expanded_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      progress_ff <= progress_in;
   end

endmodule

`default_nettype wire

FILE: hdl/graph_edge_store_connectivity.sv
// Top level of the graph edge store: vertex-count register, sequencer, row memory, result register.
//
//   Channel   Ports                                         Direction
//   request   req_valid/req_ready, req_op, req_vertex_a/b   in
//   response  rsp_valid/rsp_ready, rsp_connected, rsp_error out
//   config    csr_wr_en, csr_wr_data (num_vertices)         in
//
// Add and remove read and rewrite each endpoint row in turn through the one memory port.
// Clear drops every row's valid bit at once; an out-of-range edge skips the memory before its response.
// A check sweeps the rows in use, one memory read per cycle, repeating the sweep until one
// expands no new vertex: at most N + 1 sweeps for N vertices in use.
// Reset clears the matrix at once through per-row valid bits; num_vertices resets to 64.
// A request is taken while the previous response still waits; a stalled response holds the
// sequencer in its last state until the response register frees.
`default_nettype none

module graph_edge_store_connectivity (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [gesc_pkg::OP_W-1:0]   req_op,
   input  wire logic [gesc_pkg::VERT_W-1:0] req_vertex_a,
   input  wire logic [gesc_pkg::VERT_W-1:0] req_vertex_b,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_connected,
   output logic                             rsp_error,
   input  wire logic                        csr_wr_en,
   input  wire logic [gesc_pkg::NV_W-1:0]   csr_wr_data
);

   logic [gesc_pkg::NV_W-1:0] num_vertices_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_connected_ff;
   logic                      rsp_error_ff;
   logic                      res_free;
   gesc_pkg::result_type      res;
   gesc_pkg::mem_req_type     mem_req;
   gesc_pkg::row_type         rd_data;

   assign res_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vertices_ff <= gesc_pkg::NV_RESET;
      end else if (csr_wr_en) begin
         num_vertices_ff <= csr_wr_data;
      end
   end

   gesc_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .num_vertices (num_vertices_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_vertex_a (req_vertex_a),
      .req_vertex_b (req_vertex_b),
      .res_free     (res_free),
      .res          (res),
      .mem_req      (mem_req),
      .rd_data      (rd_data)
   );

   gesc_row_mem u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         rsp_connected_ff <= res.connected;
         rsp_error_ff     <= res.error;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_connected = rsp_connected_ff;
   assign rsp_error     = rsp_error_ff;

endmodule

`default_nettype wire

FILE: hdl/gesc_checker.sv
// Port-level checks for the graph edge store, bound to the top level.
`default_nettype none

module gesc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_connected,
   input wire logic rsp_error
);

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_connected) && $stable(rsp_error))
      else $error("response changed while stalled");

   // A response never reports both a connected graph and a bad endpoint.
   a_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_connected && rsp_error))
      else $error("response has both connected and error set");

   // The block works on one request at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Reset leaves no response pending.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

endmodule

bind graph_edge_store_connectivity gesc_checker u_gesc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_connected (rsp_connected),
   .rsp_error     (rsp_error)
);

`default_nettype wire

FILE: bench/tb_graph_edge_store_connectivity.sv
// Self-checking testbench for the graph edge store with connectivity check.
`default_nettype none

module tb_graph_edge_store_connectivity;

   typedef struct packed {
      gesc_pkg::op_type                 op;
      logic [gesc_pkg::VERT_W-1:0]      vertex_a;
      logic [gesc_pkg::VERT_W-1:0]      vertex_b;
   } graph_request_type;

   typedef struct packed {
      logic connected;
      logic error;
   } graph_answer_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [gesc_pkg::OP_W-1:0]     req_op = '0;
   logic [gesc_pkg::VERT_W-1:0]   req_vertex_a = '0;
   logic [gesc_pkg::VERT_W-1:0]   req_vertex_b = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_connected;
   logic                          rsp_error;
   logic                          csr_wr_en = 1'b0;
   logic [gesc_pkg::NV_W-1:0]     csr_wr_data = '0;

   gesc_pkg::row_type             adjacency [gesc_pkg::MAX_VERTICES];
   logic [gesc_pkg::NV_W-1:0]     vertex_count = gesc_pkg::NV_RESET;
   graph_request_type             pending_requests [$];
   graph_answer_type              awaited_answers [$];
   graph_request_type             current_request;
   graph_answer_type              oldest_answer;
   int                            requests_open = 0;
   int                            requests_queued = 0;
   int                            mismatch_count = 0;
   int                            send_wait = 0;
   int                            recv_wait = 0;
   bit                            no_idle = 1'b0;
   longint                        cycle_count = 0;
   longint                        cycle_limit = 5000;
   int                            phase_vertices [$] = '{5, 2, 8, 16, 3, 64, 11, 1, 127, 6, 32,
                                                         0, 9, 65, 4, 13, 24, 7};

   graph_edge_store_connectivity dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_vertex_a  (req_vertex_a),
      .req_vertex_b  (req_vertex_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_connected (rsp_connected),
      .rsp_error     (rsp_error),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int vertices_in_use();
      return (int'(vertex_count) > gesc_pkg::MAX_VERTICES) ? gesc_pkg::MAX_VERTICES :
             int'(vertex_count);
   endfunction

   function automatic int draw_wait();
      return no_idle ? 0 : int'($urandom_range(9, 0));
   endfunction

   function automatic logic [gesc_pkg::VERT_W-1:0] pick_vertex(int n);
      if (n == 0 || $urandom_range(9, 0) == 0) begin
         return gesc_pkg::VERT_W'($urandom);
      end
      return gesc_pkg::VERT_W'($urandom_range(n - 1, 0));
   endfunction

   function automatic graph_answer_type graph_op_answer(graph_request_type r);
      graph_answer_type  ans;
      gesc_pkg::row_type mask;
      gesc_pkg::row_type reached;
      gesc_pkg::row_type expanded;
      bit                grew;
      int                n;
      ans = '0;
      n = vertices_in_use();
      unique case (r.op)
         gesc_pkg::OP_ADD, gesc_pkg::OP_REMOVE: begin
            if (int'(r.vertex_a) >= n || int'(r.vertex_b) >= n) begin
               ans.error = 1'b1;
            end else begin
               adjacency[r.vertex_a][r.vertex_b] = (r.op == gesc_pkg::OP_ADD);
               adjacency[r.vertex_b][r.vertex_a] = (r.op == gesc_pkg::OP_ADD);
            end
         end
         gesc_pkg::OP_CHECK: begin
            if (n == 0) begin
               ans.connected = 1'b1;
            end else begin
               mask = '0;
               for (int i = 0; i < n; i++) begin
                  mask[i] = 1'b1;
               end
               reached = gesc_pkg::row_type'(1);
               expanded = '0;
               do begin
                  grew = 1'b0;
                  for (int v = 0; v < n; v++) begin
                     if (reached[v] && !expanded[v]) begin
                        expanded[v] = 1'b1;
                        reached |= adjacency[v] & mask;
                        grew = 1'b1;
                     end
                  end
               end while (grew);
               ans.connected = ((reached & mask) == mask);
            end
         end
         default: begin
            foreach (adjacency[i]) begin
               adjacency[i] = '0;
            end
         end
      endcase
      return ans;
   endfunction

   task automatic note_mismatch(string what);
      $display("tb: mismatch: %s", what);
      mismatch_count++;
   endtask

   task automatic queue_graph_op(gesc_pkg::op_type op, logic [gesc_pkg::VERT_W-1:0] a,
                                 logic [gesc_pkg::VERT_W-1:0] b);
      graph_request_type r;
      int                n;
      r.op = op;
      r.vertex_a = a;
      r.vertex_b = b;
      n = vertices_in_use();
      pending_requests.push_back(r);
      requests_open++;
      requests_queued++;
      cycle_limit += 4 * ((op == gesc_pkg::OP_CHECK) ? (n + 2) * (n + 2) + 30 : 30);
   endtask

   task automatic drain();
      @(posedge clock);
      while (requests_open != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_vertices(int value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= gesc_pkg::NV_W'(value);
      vertex_count = gesc_pkg::NV_W'(value);
      cycle_limit += 100;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_spanning_tree();
      int                          order [gesc_pkg::MAX_VERTICES];
      int                          n;
      int                          j;
      int                          t;
      int                          parent;
      int                          cut;
      logic [gesc_pkg::VERT_W-1:0] cut_a;
      logic [gesc_pkg::VERT_W-1:0] cut_b;
      n = vertices_in_use();
      cut_a = '0;
      cut_b = '0;
      for (int i = 0; i < n; i++) begin
         order[i] = i;
      end
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(i, 0);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      queue_graph_op(gesc_pkg::OP_CLEAR, pick_vertex(n), pick_vertex(n));
      cut = $urandom_range(n - 1, 1);
      for (int i = 1; i < n; i++) begin
         parent = order[$urandom_range(i - 1, 0)];
         if ($urandom_range(1, 0) == 1) begin
            queue_graph_op(gesc_pkg::OP_ADD, gesc_pkg::VERT_W'(order[i]),
                           gesc_pkg::VERT_W'(parent));
         end else begin
            queue_graph_op(gesc_pkg::OP_ADD, gesc_pkg::VERT_W'(parent),
                           gesc_pkg::VERT_W'(order[i]));
         end
         if (i == cut) begin
            cut_a = gesc_pkg::VERT_W'(order[i]);
            cut_b = gesc_pkg::VERT_W'(parent);
         end
      end
      queue_graph_op(gesc_pkg::OP_CHECK, pick_vertex(n), pick_vertex(n));
      queue_graph_op(gesc_pkg::OP_REMOVE, cut_a, cut_b);
      if ($urandom_range(1, 0) == 1) begin
         queue_graph_op(gesc_pkg::OP_ADD, pick_vertex(n), pick_vertex(n));
      end
      queue_graph_op(gesc_pkg::OP_CHECK, pick_vertex(n), pick_vertex(n));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            awaited_answers.push_back(graph_op_answer(current_request));
         end
         if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            current_request = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_op <= current_request.op;
            req_vertex_a <= current_request.vertex_a;
            req_vertex_b <= current_request.vertex_b;
            send_wait = draw_wait();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               note_mismatch("response arrived with no request outstanding");
            end else begin
               oldest_answer = awaited_answers.pop_front();
               if (rsp_connected !== oldest_answer.connected) begin
                  note_mismatch($sformatf("connected got %b want %b", rsp_connected,
                                          oldest_answer.connected));
               end
               if (rsp_error !== oldest_answer.error) begin
                  note_mismatch($sformatf("error got %b want %b", rsp_error,
                                          oldest_answer.error));
               end
               requests_open--;
            end
            recv_wait = draw_wait();
         end else if (recv_wait > 0) begin
            recv_wait--;
         end
         rsp_ready <= (recv_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int               n;
      int               target;
      int               pick;
      gesc_pkg::op_type op;
      foreach (adjacency[i]) begin
         adjacency[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_graph_op(gesc_pkg::OP_CHECK, 6'd0, 6'd0);
      queue_graph_op(gesc_pkg::OP_ADD, 6'd0, 6'd63);
      queue_graph_op(gesc_pkg::OP_ADD, 6'd63, 6'd63);
      queue_graph_op(gesc_pkg::OP_REMOVE, 6'd63, 6'd63);
      queue_graph_op(gesc_pkg::OP_REMOVE, 6'd0, 6'd63);
      queue_graph_op(gesc_pkg::OP_CLEAR, 6'd63, 6'd63);
      set_vertices(0);
      queue_graph_op(gesc_pkg::OP_CHECK, 6'd63, 6'd63);
      queue_graph_op(gesc_pkg::OP_ADD, 6'd0, 6'd0);
      queue_graph_op(gesc_pkg::OP_REMOVE, 6'd63, 6'd0);
      set_vertices(1);
      queue_graph_op(gesc_pkg::OP_ADD, 6'd0, 6'd0);
      queue_graph_op(gesc_pkg::OP_ADD, 6'd1, 6'd0);
      queue_graph_op(gesc_pkg::OP_CHECK, 6'd0, 6'd0);
      set_vertices(2);
      queue_graph_op(gesc_pkg::OP_CHECK, 6'd0, 6'd0);
      queue_graph_op(gesc_pkg::OP_ADD, 6'd1, 6'd0);
      queue_graph_op(gesc_pkg::OP_CHECK, 6'd0, 6'd0);
      queue_graph_op(gesc_pkg::OP_ADD, 6'd0, 6'd2);
      queue_graph_op(gesc_pkg::OP_REMOVE, 6'd0, 6'd1);
      queue_graph_op(gesc_pkg::OP_CHECK, 6'd0, 6'd0);
      set_vertices(127);
      queue_graph_op(gesc_pkg::OP_ADD, 6'd63, 6'd62);
      queue_graph_op(gesc_pkg::OP_ADD, 6'd62, 6'd0);
      queue_graph_op(gesc_pkg::OP_CHECK, 6'd0, 6'd0);
      set_vertices(3);
      queue_graph_op(gesc_pkg::OP_ADD, 6'd1, 6'd2);
      queue_graph_op(gesc_pkg::OP_ADD, 6'd0, 6'd1);
      queue_graph_op(gesc_pkg::OP_CHECK, 6'd0, 6'd0);

      foreach (phase_vertices[p]) begin
         set_vertices(phase_vertices[p]);
         n = vertices_in_use();
         target = requests_queued + ((n >= 32) ? 60 : 110);
         while (requests_queued < target) begin
            while (pending_requests.size() > 4) @(posedge clock);
            no_idle = ($urandom_range(3, 0) == 0);
            if (n >= 2 && $urandom_range(2, 0) == 0) begin
               queue_spanning_tree();
            end else begin
               repeat (10) begin
                  pick = $urandom_range(99, 0);
                  op = (pick < 45) ? gesc_pkg::OP_ADD :
                       ((pick < 65) ? gesc_pkg::OP_REMOVE :
                       ((pick < 94) ? gesc_pkg::OP_CHECK : gesc_pkg::OP_CLEAR));
                  queue_graph_op(op, pick_vertex(n), pick_vertex(n));
               end
            end
            if ($urandom_range(7, 0) == 0) begin
               drain();
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (awaited_answers.size() != 0) begin
         note_mismatch("responses still outstanding at end of run");
      end
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
hdl/gesc_pkg.sv
hdl/gesc_row_mem.sv
hdl/gesc_seq.sv
hdl/graph_edge_store_connectivity.sv
hdl/gesc_checker.sv
bench/tb_graph_edge_store_connectivity.sv
